// ===== rtl/tbewm_pkg.sv =====
// Package for the three band energy window meter.
// Holds shared widths, register indexes and reset values; no dependencies.
`timescale 1ns / 1ps
package tbewm_pkg;
  localparam int RING_DEPTH_DEF   = 128;
  localparam int MAX_CH_DEF       = 8;
  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int ACC_W            = 48;
  localparam int WIN_W            = 56;
  localparam int FS_W             = 40;
  localparam int SQ_SHIFT         = 14;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_NCH    = 3'd1;
  localparam logic [2:0] REG_LALPHA = 3'd2;
  localparam logic [2:0] REG_MALPHA = 3'd3;
  localparam logic [2:0] REG_SPB    = 3'd4;
  localparam logic [2:0] REG_BPU    = 3'd5;

  localparam logic [3:0]  NCH_RST    = 4'd2;
  localparam logic [15:0] LALPHA_RST = 16'd2076;
  localparam logic [15:0] MALPHA_RST = 16'd22525;
  localparam logic [15:0] SPB_RST    = 16'd4800;
  localparam logic [7:0]  BPU_RST    = 8'd100;

  typedef struct packed {
    logic       enable;
    logic [3:0] num_channels;
    logic [15:0] lo_coef;
    logic [15:0] mid_coef;
    logic [15:0] samples_per_bucket;
    logic [7:0]  buckets_per_update;
  } cfg_t;
endpackage

// ===== rtl/tbewm_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
module tbewm_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

// ===== rtl/tbewm_ring.sv =====
// Ring memory of committed bucket triples, one address port shared by write and read.
// Depends on tbewm_pkg for the accumulator width and the default depth.
`timescale 1ns / 1ps
module tbewm_ring #(
  parameter int DEPTH = tbewm_pkg::RING_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH)-1:0]       addr,
  input  logic [3*tbewm_pkg::ACC_W-1:0]  wdata,
  output logic [3*tbewm_pkg::ACC_W-1:0]  rdata
);
  logic [3*tbewm_pkg::ACC_W-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/three_band_energy_window_meter.sv =====
// Top level of the three band energy window meter.
// Uses tbewm_pkg, tbewm_mul and tbewm_ring.
//
// channel   dir  handshake         payload
// s_axis    in   tvalid/tready     tdata: sample_ch0..7, 24 bits each
// m_axis    out  tvalid/tready     tdata: low,mid,high sums, filled, due
// cfg       in   cfg_valid/ready   cfg_index, cfg_data
//
// Each sample set passes, for each channel in use, through the single
// shared multiplier (two passes per filter, three squares), then through
// three 51-bit divisions by the channel count with the bucket updates;
// no new sample set is taken until the block is back in idle.
// A commit adds the ring read and window update, then presents the result.
// Reset is synchronous; the ring needs no clearing pass. A stalled result
// holds the block busy until its transfer completes.
`timescale 1ns / 1ps
module three_band_energy_window_meter #(
  parameter int RING_DEPTH   = tbewm_pkg::RING_DEPTH_DEF,
  parameter int MAX_CHANNELS = tbewm_pkg::MAX_CH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // sample_ch0 .. sample_ch(MAX_CHANNELS-1), lowest first
  input  logic [((MAX_CHANNELS*tbewm_pkg::SAMPLE_BITS_DEF+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // low_sum[55:0], mid_sum[111:56], high_sum[167:112], buckets_filled[175:168],
  // update_due[176], zero fill to 184
  output logic [183:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  localparam int SAMPLE_BITS = tbewm_pkg::SAMPLE_BITS_DEF;
  localparam int AW  = $clog2(RING_DEPTH);
  localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FW  = $clog2(RING_DEPTH + 1);
  localparam int ACC = tbewm_pkg::ACC_W;
  localparam int WIN = tbewm_pkg::WIN_W;
  localparam logic [ACC-1:0] ACC_MAX = '1;
  localparam logic [WIN-1:0] WIN_MAX = '1;

  typedef enum logic [4:0] {
    S_IDLE, S_LD, S_LMUL, S_LHI, S_LUPD, S_MMUL, S_MHI, S_MUPD,
    S_SQ0, S_SQ1, S_SQ2, S_SQW, S_NEXT, S_DIV, S_ACC, S_RRD, S_RWAIT,
    S_WIN, S_OUT
  } state_t;

  state_t state;
  tbewm_pkg::cfg_t cfg;

  logic signed [tbewm_pkg::FS_W-1:0] low_fs [MAX_CHANNELS];
  logic signed [tbewm_pkg::FS_W-1:0] mid_fs [MAX_CHANNELS];
  logic [MAX_CHANNELS*SAMPLE_BITS-1:0] samp;
  logic [CW-1:0] ch;
  logic [3:0] nch;
  logic signed [33:0] x;
  logic signed [41:0] d;
  logic signed [41:0] s_cur;
  logic signed [41:0] lo_part;
  logic signed [25:0] lq, mq;
  logic [1:0] sq_sel;
  logic [50:0] e_low, e_mid, e_high;
  logic [1:0] dv_sel;
  logic [50:0] dv_rem;
  logic [50:0] dv_quo;
  logic [5:0]  dv_cnt;
  logic [ACC-1:0] b_low, b_mid, b_high;
  logic [WIN-1:0] w_low, w_mid, w_high;
  logic [AW-1:0] wpos;
  logic [FW-1:0] fill;
  logic [7:0] commits;
  logic [15:0] sets;
  logic due;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [3*ACC-1:0] ring_rd;
  logic ring_we;

  tbewm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
  tbewm_ring #(.DEPTH(RING_DEPTH)) u_ring (
    .clk(clk), .we(ring_we), .addr(wpos), .wdata({b_high, b_mid, b_low}),
    .rdata(ring_rd));

  assign ring_we = (state == S_WIN);
  assign cfg_ready = (state == S_IDLE);
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {7'd0, due, (8)'(fill), w_high, w_mid, w_low};

  // Multiplier operand select. Filter path: alpha times the low 16 bits of
  // the difference, then alpha times the floored high part. Square path:
  // band values.
  logic signed [25:0] band;
  always_comb begin
    case (sq_sel)
      2'd0:    band = lq;
      2'd1:    band = mq - lq;
      default: band = 26'(x) - mq;
    endcase
    mul_a = 33'sd0;
    mul_b = 33'sd0;
    if (state == S_LMUL || state == S_LHI || state == S_MMUL || state == S_MHI) begin
      mul_a = {17'd0, (state == S_LMUL || state == S_LHI) ? cfg.lo_coef : cfg.mid_coef};
      if (state == S_LMUL || state == S_MMUL) begin
        mul_b = {1'b0, 32'(d[15:0])};
      end else begin
        mul_b = 33'(d >>> 16);
      end
    end else begin
      mul_a = 33'(band);
      mul_b = 33'(band);
    end
  end

  // New filter state: s + a*floor(d/2^16) + floor(a*(d mod 2^16)/2^16)
  logic signed [41:0] fs_new;
  assign fs_new = s_cur + 42'(mul_p) + lo_part;

  logic [SAMPLE_BITS-1:0] raw;
  assign raw = samp[ch*SAMPLE_BITS +: SAMPLE_BITS];

  // Saturating helper for the bucket add
  logic [ACC:0] add_b;
  logic [ACC-1:0] bsel;
  always_comb begin
    case (dv_sel)
      2'd0:    bsel = b_low;
      2'd1:    bsel = b_mid;
      default: bsel = b_high;
    endcase
    add_b = {1'b0, bsel} + {1'b0, dv_quo[ACC-1:0]};
  end

  logic [WIN-1:0] old_v;
  always_comb begin
    case (dv_sel)
      2'd0:    old_v = (WIN)'(ring_rd[ACC-1:0]);
      2'd1:    old_v = (WIN)'(ring_rd[2*ACC-1:ACC]);
      default: old_v = (WIN)'(ring_rd[3*ACC-1:2*ACC]);
    endcase
  end

  logic [50:0] e_sel;
  always_comb begin
    case (dv_sel)
      2'd0:    e_sel = e_low;
      2'd1:    e_sel = e_mid;
      default: e_sel = e_high;
    endcase
  end

  logic [51:0] dv_try;
  assign dv_try = {dv_rem, e_sel[6'd50 - dv_cnt]} - {48'd0, nch};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cfg <= '{1'b0, tbewm_pkg::NCH_RST, tbewm_pkg::LALPHA_RST,
               tbewm_pkg::MALPHA_RST, tbewm_pkg::SPB_RST, tbewm_pkg::BPU_RST};
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        low_fs[i] <= '0;
        mid_fs[i] <= '0;
      end
      b_low <= '0; b_mid <= '0; b_high <= '0;
      w_low <= '0; w_mid <= '0; w_high <= '0;
      wpos <= '0; fill <= '0; commits <= '0; sets <= '0;
      due <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              tbewm_pkg::REG_ENABLE: cfg.enable <= cfg_data[0];
              tbewm_pkg::REG_NCH:    cfg.num_channels <= cfg_data[3:0];
              tbewm_pkg::REG_LALPHA: cfg.lo_coef <= cfg_data;
              tbewm_pkg::REG_MALPHA: cfg.mid_coef <= cfg_data;
              tbewm_pkg::REG_SPB:    cfg.samples_per_bucket <= cfg_data;
              tbewm_pkg::REG_BPU:    cfg.buckets_per_update <= cfg_data[7:0];
              default: ;
            endcase
          end
          if (s_axis_tvalid && cfg.enable && cfg.num_channels != 4'd0 &&
              32'(cfg.num_channels) <= MAX_CHANNELS) begin
            samp <= s_axis_tdata[MAX_CHANNELS*SAMPLE_BITS-1:0];
            nch <= cfg.num_channels;
            ch <= '0;
            e_low <= '0; e_mid <= '0; e_high <= '0;
            state <= S_LD;
          end
        end
        S_LD: begin
          x <= 34'(signed'(raw));
          s_cur <= 42'(low_fs[ch]);
          d <= (42'(signed'(raw)) <<< 16) - 42'(low_fs[ch]);
          state <= S_LMUL;
        end
        S_LMUL: state <= S_LHI;
        S_LHI: begin
          lo_part <= 42'(mul_p >>> 16);
          state <= S_LUPD;
        end
        S_LUPD: begin
          low_fs[ch] <= 40'(fs_new);
          lq <= 26'(fs_new >>> 16);
          s_cur <= 42'(mid_fs[ch]);
          d <= (42'(x) <<< 16) - 42'(mid_fs[ch]);
          state <= S_MMUL;
        end
        S_MMUL: state <= S_MHI;
        S_MHI: begin
          lo_part <= 42'(mul_p >>> 16);
          state <= S_MUPD;
        end
        S_MUPD: begin
          mid_fs[ch] <= 40'(fs_new);
          mq <= 26'(fs_new >>> 16);
          sq_sel <= 2'd0;
          state <= S_SQ0;
        end
        S_SQ0: begin
          sq_sel <= 2'd1;
          state <= S_SQ1;
        end
        S_SQ1: begin
          e_low <= e_low + 51'(mul_p[65:14]);
          sq_sel <= 2'd2;
          state <= S_SQ2;
        end
        S_SQ2: begin
          e_mid <= e_mid + 51'(mul_p[65:14]);
          state <= S_SQW;
        end
        S_SQW: begin
          e_high <= e_high + 51'(mul_p[65:14]);
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (32'(ch) + 1 >= 32'(nch)) begin
            dv_sel <= 2'd0; dv_cnt <= '0; dv_rem <= '0; dv_quo <= '0;
            state <= S_DIV;
          end else begin
            ch <= ch + 1'b1;
            state <= S_LD;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          if (!dv_try[51]) begin
            dv_rem <= dv_try[50:0];
            dv_quo <= {dv_quo[49:0], 1'b1};
          end else begin
            dv_rem <= {dv_rem[49:0], e_sel[6'd50 - dv_cnt]};
            dv_quo <= {dv_quo[49:0], 1'b0};
          end
          if (dv_cnt == 6'd50) state <= S_ACC;
          else dv_cnt <= dv_cnt + 1'b1;
        end
        S_ACC: begin
          if (add_b[ACC] || dv_quo[50:ACC] != '0) begin
            case (dv_sel)
              2'd0: b_low <= ACC_MAX;
              2'd1: b_mid <= ACC_MAX;
              default: b_high <= ACC_MAX;
            endcase
          end else begin
            case (dv_sel)
              2'd0: b_low <= add_b[ACC-1:0];
              2'd1: b_mid <= add_b[ACC-1:0];
              default: b_high <= add_b[ACC-1:0];
            endcase
          end
          if (dv_sel == 2'd2) begin
            sets <= sets + 1'b1;
            if (sets + 1'b1 < cfg.samples_per_bucket) begin
              state <= S_IDLE;
            end else begin
              dv_sel <= 2'd0;
              state <= S_RRD;
            end
          end else begin
            dv_sel <= dv_sel + 1'b1;
            dv_cnt <= '0; dv_rem <= '0; dv_quo <= '0;
            state <= S_DIV;
          end
        end
        S_RRD: state <= S_RWAIT;
        S_RWAIT: begin
          // drop the oldest bucket once the ring is full
          if (32'(fill) >= RING_DEPTH) begin
            w_low  <= (old_v > w_low)  ? '0 : w_low - (WIN)'(ring_rd[ACC-1:0]);
            w_mid  <= (ring_rd[2*ACC-1:ACC] > w_mid) ? '0 :
                      w_mid - (WIN)'(ring_rd[2*ACC-1:ACC]);
            w_high <= (ring_rd[3*ACC-1:2*ACC] > w_high) ? '0 :
                      w_high - (WIN)'(ring_rd[3*ACC-1:2*ACC]);
          end else begin
            fill <= fill + 1'b1;
          end
          state <= S_WIN;
        end
        S_WIN: begin
          w_low  <= ({1'b0, w_low} + (WIN+1)'(b_low)) > (WIN+1)'(WIN_MAX) ?
                    WIN_MAX : w_low + (WIN)'(b_low);
          w_mid  <= ({1'b0, w_mid} + (WIN+1)'(b_mid)) > (WIN+1)'(WIN_MAX) ?
                    WIN_MAX : w_mid + (WIN)'(b_mid);
          w_high <= ({1'b0, w_high} + (WIN+1)'(b_high)) > (WIN+1)'(WIN_MAX) ?
                    WIN_MAX : w_high + (WIN)'(b_high);
          wpos <= (32'(wpos) + 1 >= RING_DEPTH) ? '0 : wpos + 1'b1;
          sets <= '0;
          b_low <= '0; b_mid <= '0; b_high <= '0;
          if (32'(commits) + 1 >= 32'(cfg.buckets_per_update)) begin
            commits <= '0;
            due <= 1'b1;
          end else begin
            commits <= commits + 1'b1;
            due <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= RING_DEPTH) else $error("fill above ring depth");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && cfg.enable && cfg.num_channels != 4'd0 &&
    32'(cfg.num_channels) <= MAX_CHANNELS |=> !s_axis_tready)
    else $error("accepted while busy");
  a_cmt_clr: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> sets == 16'd0) else $error("bucket count not cleared");
`endif
endmodule
